@@ rtl/aes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte functions for the AES round unit.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int RND_W      = 4;

  // Register indexes
  localparam logic [1:0] REG_KEY_HIGH   = 2'd0;
  localparam logic [1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [1:0] REG_NUM_ROUNDS = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } rsp_t;

  // Round control from sequencer to datapath
  typedef struct packed {
    logic load;
    logic fwd_round;
    logic fwd_last;
    logic inv_first;
    logic inv_round;
    logic inv_last;
    logic key_fwd;
    logic key_bwd;
  } rnd_ctl_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  // Multiply by x in GF(2^8), polynomial 0x11B
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  // Inverse of xtime: divide by x
  function automatic logic [7:0] xdiv(input logic [7:0] a);
    return a[0] ? ({1'b0, a[7:1]} ^ 8'h8D) : {1'b0, a[7:1]};
  endfunction

  // Byte i of a 128-bit word, byte 0 on top
  function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
    return w[127 - 8*i -: 8];
  endfunction

endpackage

@@ rtl/aes_key_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round key unit
// Steps the AES-128 key schedule one round forward or backward per cycle.
// ----------------------------------------------------------------------------
module aes_key_unit (
  input  logic             clk,
  input  logic             init,
  input  logic [127:0]     init_key,
  input  logic [7:0]       init_rcon,
  input  aes_pkg::rnd_ctl_t ctl,
  output logic [127:0]     rkey
);
  import aes_pkg::*;

  logic [127:0] key;
  logic [7:0]   rcon;
  logic [127:0] fwd_key;
  logic [127:0] bwd_key;
  logic [7:0]   bwd_rcon;
  logic [31:0]  fwd_t;
  logic [31:0]  bwd_t;
  logic [31:0]  pw3;

  // Forward step: w0' = w0 ^ T(w3), wi' = wi ^ wi-1'
  always_comb begin
    fwd_t = {FWD_BOX[byte_at(key, 13)] ^ rcon, FWD_BOX[byte_at(key, 14)],
             FWD_BOX[byte_at(key, 15)], FWD_BOX[byte_at(key, 12)]};
    fwd_key[127:96] = key[127:96] ^ fwd_t;
    fwd_key[95:64]  = key[95:64] ^ fwd_key[127:96];
    fwd_key[63:32]  = key[63:32] ^ fwd_key[95:64];
    fwd_key[31:0]   = key[31:0] ^ fwd_key[63:32];
  end

  // Backward step: rcon register holds the constant of the next forward step,
  // so the step that produced the current key used xdiv(rcon)
  always_comb begin
    bwd_rcon        = xdiv(rcon);
    pw3             = key[31:0] ^ key[63:32];
    bwd_t           = {FWD_BOX[pw3[23:16]] ^ bwd_rcon, FWD_BOX[pw3[15:8]],
                       FWD_BOX[pw3[7:0]], FWD_BOX[pw3[31:24]]};
    bwd_key[31:0]   = pw3;
    bwd_key[63:32]  = key[63:32] ^ key[95:64];
    bwd_key[95:64]  = key[95:64] ^ key[127:96];
    bwd_key[127:96] = key[127:96] ^ bwd_t;
  end

  // Key register
  always_ff @(posedge clk) begin
    if (init) begin
      key  <= init_key;
      rcon <= init_rcon;
    end else if (ctl.key_fwd) begin
      key  <= fwd_key;
      rcon <= xtime(rcon);
    end else if (ctl.key_bwd) begin
      key  <= bwd_key;
      rcon <= bwd_rcon;
    end
  end

  assign rkey = key;

endmodule

@@ rtl/aes_round_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round unit
// Holds the cipher state and applies one forward or inverse round per cycle.
// ----------------------------------------------------------------------------
module aes_round_unit (
  input  logic              clk,
  input  aes_pkg::rnd_ctl_t ctl,
  input  logic [127:0]      load_data,
  input  logic [127:0]      rkey,
  output logic [127:0]      state_q
);
  import aes_pkg::*;

  logic [127:0] st;
  logic [127:0] fsub;
  logic [127:0] fmix;
  logic [127:0] isub_in;
  logic [127:0] isub;
  logic [127:0] ark;
  logic [127:0] imix;
  logic [127:0] st_next;

  // SubBytes + ShiftRows
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fsub[127 - 8*(c*4 + r) -: 8] = FWD_BOX[byte_at(st, ((c + r) & 3)*4 + r)];
      end
    end
  end

  // Forward MixColumns on fsub
  always_comb begin
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = byte_at(fsub, c*4 + r);
      for (int r = 0; r < 4; r++) begin
        fmix[127 - 8*(c*4 + r) -: 8] = xtime(a[r]) ^ xtime(a[(r+1)&3]) ^ a[(r+1)&3]
                                       ^ a[(r+2)&3] ^ a[(r+3)&3];
      end
    end
  end

  // Inverse MixColumns on state ^ key
  always_comb begin
    logic [7:0] a [4];
    logic [7:0] x2, x4, x8;
    ark = st ^ rkey;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = byte_at(ark, c*4 + r);
      for (int r = 0; r < 4; r++) begin
        imix[127 - 8*(c*4 + r) -: 8] = 8'h00;
      end
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          x2 = xtime(a[(r+k)&3]);
          x4 = xtime(x2);
          x8 = xtime(x4);
          // coefficients 0E, 0B, 0D, 09
          unique case (k)
            0: imix[127 - 8*(c*4+r) -: 8] ^= x8 ^ x4 ^ x2;
            1: imix[127 - 8*(c*4+r) -: 8] ^= x8 ^ x2 ^ a[(r+k)&3];
            2: imix[127 - 8*(c*4+r) -: 8] ^= x8 ^ x4 ^ a[(r+k)&3];
            default: imix[127 - 8*(c*4+r) -: 8] ^= x8 ^ a[(r+k)&3];
          endcase
        end
      end
    end
  end

  // Inverse ShiftRows + SubBytes: after the key add on the first inverse
  // step, after key add and inverse MixColumns on the middle ones
  always_comb begin
    isub_in = ctl.inv_round ? imix : ark;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        isub[127 - 8*(((c + r) & 3)*4 + r) -: 8] = INV_BOX[byte_at(isub_in, c*4 + r)];
      end
    end
  end

  // State update select; inv_last is a plain key add
  always_comb begin
    priority if (ctl.load)      st_next = load_data;
    else if (ctl.fwd_round)     st_next = fmix ^ rkey;
    else if (ctl.fwd_last)      st_next = fsub ^ rkey;
    else if (ctl.inv_first)     st_next = isub;
    else if (ctl.inv_round)     st_next = isub;
    else if (ctl.inv_last)      st_next = ark;
    else                        st_next = st;
  end

  always_ff @(posedge clk) begin
    st <= st_next;
  end

  assign state_q = st;

endmodule

@@ rtl/aes128_block_cipher_var_rounds_unit.sv @@
`timescale 1ns / 1ps
// Steps (N = rounds): encrypt is key add, N rounds, output; decrypt is N key steps
// forward, then N+1 inverse steps, then output.
// One request at a time; busy stays high through done, so the next request is taken
// only once the sequencer is back in idle.
// Reset (synchronous, rst): key = 0, rounds = 10, sequencer idle.
// done is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// AES-128 variable-round block cipher
// Sequencer, APB register file and wiring of the round and key units.
// ----------------------------------------------------------------------------
module aes128_block_cipher_var_rounds_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          start,
  input  aes_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output aes_pkg::rsp_t rsp
);
  import aes_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KEYUP = 5'b00010,
    S_FWD   = 5'b00100,
    S_INV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [63:0]      key_high, key_low;
  logic [RND_W-1:0] num_rounds;
  logic [RND_W-1:0] rounds_eff;
  logic [RND_W-1:0] cnt;
  logic             kind;
  rnd_ctl_t         ctl;
  logic [127:0]     rkey;
  logic [127:0]     st_q;
  logic [127:0]     in_data;
  logic             wr;
  logic [1:0]       reg_idx;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      num_rounds <= RND_W'(10);
    end else if (wr) begin
      unique case (reg_idx)
        REG_KEY_HIGH:   key_high   <= pwdata;
        REG_KEY_LOW:    key_low    <= pwdata;
        REG_NUM_ROUNDS: num_rounds <= pwdata[RND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_HIGH:   prdata = key_high;
      REG_KEY_LOW:    prdata = key_low;
      REG_NUM_ROUNDS: prdata = {{(64-RND_W){1'b0}}, num_rounds};
      default:        prdata = '0;
    endcase
  end

  // Round count clamp
  always_comb begin
    priority if (num_rounds == '0)              rounds_eff = RND_W'(1);
    else if (num_rounds > RND_W'(MAX_ROUNDS))   rounds_eff = RND_W'(MAX_ROUNDS);
    else                                        rounds_eff = num_rounds;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_KEYUP;
        end
      end
      S_KEYUP: begin
        // encrypt: add round key 0; decrypt: walk key forward N steps
        if (!kind) begin
          ctl.inv_last = 1'b1;
          ctl.key_fwd  = 1'b1;
          state_next   = S_FWD;
        end else begin
          ctl.key_fwd = 1'b1;
          if (cnt == RND_W'(1)) state_next = S_INV;
        end
      end
      S_FWD: begin
        ctl.key_fwd = 1'b1;
        if (cnt == RND_W'(1)) begin
          ctl.fwd_last = 1'b1;
          state_next   = S_OUT;
        end else begin
          ctl.fwd_round = 1'b1;
        end
      end
      S_INV: begin
        // key register holds round key cnt
        if (cnt == RND_W'(0)) begin
          ctl.inv_last = 1'b1;                           // add key 0
          state_next   = S_OUT;
        end else begin
          ctl.key_bwd = 1'b1;
          if (cnt == rounds_eff) ctl.inv_first = 1'b1;   // add key N
          else ctl.inv_round = 1'b1;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      kind  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        cnt  <= rounds_eff;
        kind <= req.kind;
      end else if (state == S_KEYUP && kind) begin
        cnt <= (cnt == RND_W'(1)) ? rounds_eff : cnt - RND_W'(1);
      end else if (state == S_FWD || state == S_INV) begin
        cnt <= cnt - RND_W'(1);
      end
    end
  end

  assign in_data = {req.block_high, req.block_low};

  aes_key_unit u_key (
    .clk       (clk),
    .init      (ctl.load),
    .init_key  ({key_high, key_low}),
    .init_rcon (8'h01),
    .ctl       (ctl),
    .rkey      (rkey)
  );

  aes_round_unit u_round (
    .clk       (clk),
    .ctl       (ctl),
    .load_data (in_data),
    .rkey      (rkey),
    .state_q   (st_q)
  );

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);
  assign rsp  = rsp_t'(st_q);

endmodule
